// ===== sv/ldp_pkg.sv =====
// Shared package for the largest-differencing partition block.
// Holds sizing constants, the controller state type and the command/status structs.
// No dependencies.
package ldp_pkg;

    // Store depth and number width.
    localparam int MAX_ITEMS  = 128;
    localparam int VALUE_BITS = 48;

    // Derived widths.
    localparam int IDX_BITS   = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    // Controller states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_WR_TOP,
        S_WR_NEXT,
        S_DONE
    } ldp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // input channel ready
        logic scan_step;  // issue one store read of the scan
        logic wr_top;     // write the difference over the largest entry
        logic wr_next;    // zero the second largest entry, end of round
        logic out_load;   // move the residue into the output register
    } ldp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_last;     // a marked input transaction is offered
        logic multi;       // the set will hold at least two numbers
        logic scan_end;    // the current read is the last loaded entry
        logic rounds_done; // the current round is the final one
        logic out_free;    // the output register can take a result
    } ldp_status_t;

endpackage

// ===== sv/ldp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the number store; no package dependencies.
module ldp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ldp_ctrl.sv =====
// Controller state machine for the largest-differencing partition block.
// Depends on ldp_pkg for the state type and the command/status structs.
module ldp_ctrl import ldp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  ldp_status_t status,
    output ldp_cmd_t    cmd
);

    ldp_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (status.in_last) begin
                    state_next = status.multi ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (status.scan_end) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:   state_next = S_WR_TOP;
            S_WR_TOP:  state_next = S_WR_NEXT;
            S_WR_NEXT: state_next = status.rounds_done ? S_DONE : S_SCAN;
            S_DONE: begin
                if (status.out_free) begin
                    state_next = S_LOAD;
                end
            end
            default:   state_next = S_LOAD;
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_LOAD:    cmd.accept    = 1'b1;
            S_SCAN:    cmd.scan_step = 1'b1;
            S_DRAIN:   cmd           = '0;
            S_WR_TOP:  cmd.wr_top    = 1'b1;
            S_WR_NEXT: cmd.wr_next   = 1'b1;
            S_DONE:    cmd.out_load  = status.out_free;
            default:   cmd           = '0;
        endcase
    end

endmodule

// ===== sv/ldp_datapath.sv =====
// Datapath of the largest-differencing partition block: number store, scan
// tracker, round counter and output register. Depends on ldp_pkg and ldp_ram.
module ldp_datapath import ldp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ldp_cmd_t              cmd,
    output ldp_status_t           status,
    input  logic                  s_tvalid,
    input  logic [TDATA_BITS-1:0] s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic                  m_tuser
);

    logic [CNT_BITS-1:0]   count_reg;
    logic                  overflow_reg;
    logic [CNT_BITS-1:0]   rounds_reg;
    logic [IDX_BITS-1:0]   rd_addr_reg;
    logic                  rd_valid_reg;
    logic [IDX_BITS-1:0]   rd_idx_reg;
    logic [VALUE_BITS-1:0] top_reg, next_reg;
    logic [IDX_BITS-1:0]   top_idx_reg, next_idx_reg;
    logic [VALUE_BITS-1:0] residue_reg;
    logic                  m_valid_reg;
    logic [VALUE_BITS-1:0] m_residue_reg;
    logic                  m_overflow_reg;

    logic                  in_fire;
    logic                  has_room;
    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS-1:0] rd_data;
    logic [VALUE_BITS-1:0] diff;
    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [CNT_BITS-1:0]   last_idx;

    assign in_fire  = cmd.accept && s_tvalid;
    assign has_room = (count_reg != CNT_BITS'(MAX_ITEMS));
    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign diff     = top_reg - next_reg;
    assign last_idx = count_reg - CNT_BITS'(1);

    // Store write port: loading, difference write, or zeroing.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_BITS-1:0];
        ram_wdata = in_value;
        if (in_fire && has_room) begin
            ram_we = 1'b1;
        end else if (cmd.wr_top) begin
            ram_we    = 1'b1;
            ram_waddr = top_idx_reg;
            ram_wdata = diff;
        end else if (cmd.wr_next) begin
            ram_we    = 1'b1;
            ram_waddr = next_idx_reg;
            ram_wdata = '0;
        end
    end

    ldp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (rd_data)
    );

    // Set bookkeeping: fill count, dropped-number flag and round counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            rounds_reg   <= '0;
        end else begin
            if (in_fire) begin
                if (has_room) begin
                    count_reg <= count_reg + CNT_BITS'(1);
                end else begin
                    overflow_reg <= 1'b1;
                end
                // Rounds needed: final count minus one.
                rounds_reg <= has_room ? count_reg : last_idx;
            end else if (cmd.wr_next) begin
                rounds_reg <= rounds_reg - CNT_BITS'(1);
            end
            if (cmd.out_load) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    // Scan read address and the index of the data returning next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.scan_step) begin
                rd_addr_reg <= rd_addr_reg + IDX_BITS'(1);
            end else begin
                rd_addr_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_addr_reg;
    end

    // Track the largest and second largest entries; strict compares let the
    // lower index win a tie. Index 1 always fills the runner-up slot, or moves index 0 there.
    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            if (rd_idx_reg == '0) begin
                top_reg     <= rd_data;
                top_idx_reg <= rd_idx_reg;
            end else if (rd_data > top_reg) begin
                next_reg     <= top_reg;
                next_idx_reg <= top_idx_reg;
                top_reg      <= rd_data;
                top_idx_reg  <= rd_idx_reg;
            end else if (rd_idx_reg == IDX_BITS'(1) || rd_data > next_reg) begin
                next_reg     <= rd_data;
                next_idx_reg <= rd_idx_reg;
            end
        end
    end

    // After the final round only the last difference can be nonzero, so it
    // is the residue; a single-number set leaves that number.
    always_ff @(posedge aclk) begin
        if (in_fire && has_room) begin
            residue_reg <= in_value;
        end else if (cmd.wr_top) begin
            residue_reg <= diff;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_residue_reg  <= residue_reg;
            m_overflow_reg <= overflow_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_BITS'(m_residue_reg);
    assign m_tuser  = m_overflow_reg;

    // Status to the controller.
    assign status.in_last     = s_tvalid && s_tlast;
    assign status.multi       = (count_reg != '0);
    assign status.scan_end    = (rd_addr_reg == last_idx[IDX_BITS-1:0]);
    assign status.rounds_done = (rounds_reg == CNT_BITS'(1));
    assign status.out_free    = !m_valid_reg || m_tready;

endmodule

// ===== sv/largest_differencing_partition.sv =====
// Top level of the largest-differencing partition block.
// Depends on ldp_pkg, ldp_ctrl and ldp_datapath.
//
// Usage: numbers of a set arrive on the s_ stream channel, one per
// transaction, the last one marked by s_tlast. Each number is written into the
// store as it is accepted. A marked transaction closes the set; the block then
// runs count-1 differencing rounds, each replacing the two largest entries
// by their difference and a zero, and returns the partition residue as one
// transaction on the m_ channel, with m_tuser set if numbers were dropped
// because the store of MAX_ITEMS entries was full.
// Rounds: each round is one store read per loaded entry through the single
// read port, a drain step to finish the last compare and two store writes;
// after the final round the result moves into the output register, and a set
// of one number goes there without any round.
// s_tready is low from the marked transaction until the result is handed to
// the output register. If the receiver stalls, the result holds in the output
// register and the next set is accepted meanwhile; a second result waits
// in the block until the first is taken.
// Reset (aresetn low, synchronous) empties the set and the output register;
// store contents are not cleared and need not be.
module largest_differencing_partition import ldp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // [47:0] value
    input  logic                  s_tlast,   // is_last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // [47:0] residue
    output logic                  m_tuser    // [0] overflow
);

    ldp_cmd_t    cmd;
    ldp_status_t status;

    ldp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    ldp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.accept;

endmodule

// ===== tb/ldp_residue_checker.sv =====
// Checker for the largest-differencing partition block: watches both stream channels,
// predicts the residue of every closed set and compares it with the returned transaction.
// Depends on ldp_pkg for the store depth and the number width.
module ldp_residue_checker import ldp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // [47:0] value
    input  logic                  s_tlast,   // is_last
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_BITS-1:0] m_tdata,   // [47:0] residue
    input  logic                  m_tuser,   // [0] overflow
    output int unsigned           mismatch_count,
    output int unsigned           residues_pending,
    output int unsigned           residues_checked,
    output int unsigned           overflow_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [VALUE_BITS-1:0] number_t;

    typedef struct packed {
        number_t residue;
        logic    overflow;
    } partition_outcome_t;

    // Private copy of the set being loaded.
    number_t            held_numbers [MAX_ITEMS];
    int unsigned        held_count = 0;
    bit                 dropped_any = 1'b0;
    partition_outcome_t pending_outcomes [$];

    int unsigned mismatches_seen = 0;
    int unsigned checked_seen = 0;
    int unsigned overflow_seen_count = 0;

    // Print one line per mismatch and count it.
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches_seen++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Run the differencing rounds over the first n held numbers and return the
    // first nonzero entry left, or zero. Ties go to the lower index.
    function automatic number_t settle_residue(input int unsigned n);
        int unsigned round, k, hi_at, lo_at;
        number_t     found;
        found = '0;
        for (round = 1; round < n; round++) begin
            hi_at = 0;
            lo_at = 1;
            if (held_numbers[1] > held_numbers[0]) begin
                hi_at = 1;
                lo_at = 0;
            end
            for (k = 2; k < n; k++) begin
                if (held_numbers[k] > held_numbers[hi_at]) begin
                    lo_at = hi_at;
                    hi_at = k;
                end else if (held_numbers[k] > held_numbers[lo_at]) begin
                    lo_at = k;
                end
            end
            held_numbers[hi_at] = held_numbers[hi_at] - held_numbers[lo_at];
            held_numbers[lo_at] = '0;
        end
        for (k = n; k > 0; k--) begin
            if (held_numbers[k-1] != '0)
                found = held_numbers[k-1];
        end
        return found;
    endfunction

    // Track accepted numbers, predict on the marked one and compare each result.
    always @(posedge aclk) begin
        partition_outcome_t want;
        if (!aresetn) begin
            held_count  = 0;
            dropped_any = 1'b0;
            pending_outcomes.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (held_count < MAX_ITEMS) begin
                    held_numbers[held_count] = s_tdata[VALUE_BITS-1:0];
                    held_count++;
                end else begin
                    dropped_any = 1'b1;
                end
                if (s_tlast) begin
                    want.residue  = settle_residue(held_count);
                    want.overflow = dropped_any;
                    pending_outcomes.push_back(want);
                    held_count  = 0;
                    dropped_any = 1'b0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    flag_mismatch("result with no set waiting", 64'(m_tdata), 64'(0));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_tdata[VALUE_BITS-1:0] !== want.residue)
                        flag_mismatch("residue", 64'(m_tdata[VALUE_BITS-1:0]),
                                      64'(want.residue));
                    if (m_tuser !== want.overflow)
                        flag_mismatch("overflow flag", 64'(m_tuser), 64'(want.overflow));
                    checked_seen++;
                    if (want.overflow)
                        overflow_seen_count++;
                end
            end
        end
        mismatch_count   <= mismatches_seen;
        residues_pending <= pending_outcomes.size();
        residues_checked <= checked_seen;
        overflow_results <= overflow_seen_count;
    end

endmodule

// ===== tb/tb_largest_differencing_partition.sv =====
// Testbench top for the largest-differencing partition block: clock, reset, number
// sets on the input stream, receiver stalls, watchdog and verdict.
// Depends on ldp_pkg, largest_differencing_partition and ldp_residue_checker.
module tb_largest_differencing_partition;
    import ldp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [VALUE_BITS-1:0] number_t;

    localparam number_t     ALL_ONES       = {VALUE_BITS{1'b1}};
    localparam int unsigned NUMBER_GOAL    = 1950;
    localparam int unsigned WATCHDOG_LIMIT = 100000;
    localparam int unsigned TAIL_CYCLES    = 40;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata  = '0;   // [47:0] value
    logic                  s_tlast  = 1'b0; // is_last
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;         // [47:0] residue
    logic                  m_tuser;         // [0] overflow

    int unsigned mismatch_count;
    int unsigned residues_pending;
    int unsigned residues_checked;
    int unsigned overflow_results;

    int unsigned burst_left = 0;
    int unsigned numbers_sent = 0;
    int unsigned sets_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned ready_style = 0;
    int unsigned ready_phase_left = 0;
    number_t     prior_number = '0;

    largest_differencing_partition DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ldp_residue_checker checker_inst (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .mismatch_count   (mismatch_count),
        .residues_pending (residues_pending),
        .residues_checked (residues_checked),
        .overflow_results (overflow_results)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: switches between always ready, coin-flip ready and long stalls.
    always @(posedge aclk) begin
        if (ready_phase_left == 0) begin
            ready_style      <= $urandom_range(0, 2);
            ready_phase_left <= $urandom_range(50, 400);
        end else begin
            ready_phase_left <= ready_phase_left - 1;
        end
        case (ready_style)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one number and wait for its transaction; gaps fall between bursts.
    task automatic send_number(input number_t value, input bit last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        numbers_sent++;
        if (last)
            sets_sent++;
    endtask

    // Random number: zeros, all ones, repeats for ties, small values, single bits
    // and full-width values.
    function automatic number_t draw_number();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2: return prior_number;
            3, 4: return number_t'($urandom_range(0, 255));
            5: return number_t'(1) << $urandom_range(0, VALUE_BITS - 1);
            default: return number_t'({$urandom(), $urandom()});
        endcase
    endfunction

    // Send a set of n random numbers, the last one marked.
    task automatic send_random_set(input int unsigned n);
        int unsigned k;
        number_t     value;
        for (k = 1; k <= n; k++) begin
            value = draw_number();
            prior_number = value;
            send_number(value, k == n);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int unsigned set_size;
        int unsigned waited;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single numbers at both extremes.
        send_number('0, 1'b1);
        send_number(ALL_ONES, 1'b1);
        // Equal largest values cancel; a zero partner leaves the other.
        send_number(ALL_ONES, 1'b0);
        send_number(ALL_ONES, 1'b1);
        send_number(ALL_ONES, 1'b0);
        send_number('0, 1'b1);
        // Three-way tie and an all-zero set.
        send_number(number_t'(5), 1'b0);
        send_number(number_t'(5), 1'b0);
        send_number(number_t'(5), 1'b1);
        send_number('0, 1'b0);
        send_number('0, 1'b0);
        send_number('0, 1'b1);
        // Alternating bit patterns.
        send_number({(VALUE_BITS/2){2'b10}}, 1'b0);
        send_number({(VALUE_BITS/2){2'b01}}, 1'b1);
        // A textbook set where differencing leaves 2.
        send_number(number_t'(8), 1'b0);
        send_number(number_t'(7), 1'b0);
        send_number(number_t'(6), 1'b0);
        send_number(number_t'(5), 1'b0);
        send_number(number_t'(4), 1'b1);

        // A set that exactly fills the store, then one that overflows it so
        // the marked number itself is dropped.
        send_random_set(MAX_ITEMS);
        send_random_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 12));

        // Random sets, mostly small, a few large or at or over capacity.
        while (numbers_sent < NUMBER_GOAL) begin
            case ($urandom_range(0, 99)) inside
                [0:69]:  set_size = $urandom_range(1, 8);
                [70:91]: set_size = $urandom_range(9, 32);
                [92:96]: set_size = $urandom_range(33, MAX_ITEMS - 1);
                default: set_size = $urandom_range(MAX_ITEMS, MAX_ITEMS + 8);
            endcase
            send_random_set(set_size);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain the outstanding residues, then watch for stray results.
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (residues_pending != 0 && waited < WATCHDOG_LIMIT);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d numbers in %0d sets; %0d residues checked, %0d flagged overflow.",
                 numbers_sent, sets_sent, residues_checked, overflow_results);
        if (mismatch_count == 0 && residues_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d residues never returned",
                     mismatch_count, residues_pending);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
